// ===== hdl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros.svh
// shared concurrent assertion macros for the date classifier checker
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked on every rising edge while out of reset
`define GDC_ASSERT(lbl, clk, rst_n, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
	else $error("gdc assertion failed");

// a request that is stalled stays offered on the next edge
`define GDC_ASSERT_STALL(lbl, clk, rst_n, vld, rdy) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (vld && !rdy) |=> vld) \
	else $error("gdc stalled request was withdrawn");

`endif

// ===== hdl/gdc_pkg.sv =====
// ----------------------------------------------------------------------------
// gdc_pkg
// widths, calendar tables, division constants and the stage payload type
// ----------------------------------------------------------------------------
package gdc_pkg;

	// field widths
	localparam int DAY_W   = 5;
	localparam int MONTH_W = 4;
	localparam int YEAR_W  = 14;
	localparam int DOW_W   = 3;
	localparam int MLEN_W  = 5;
	localparam int DOY_W   = 9;
	localparam int MASK_W  = 7;
	localparam int YY_W    = 15;
	localparam int SUM_W   = 15;
	localparam int NUM_MONTHS = 12;

	// month codes
	localparam logic [MONTH_W-1:0] MONTH_JAN = 4'd1;
	localparam logic [MONTH_W-1:0] MONTH_FEB = 4'd2;
	localparam logic [MONTH_W-1:0] MONTH_DEC = 4'd12;

	// one 400-year cycle, keeps the shifted year positive
	localparam logic [YY_W-1:0] CYCLE_YEARS = 15'd400;

	// x / 25 == (x * DIV25_MULT) >> DIV25_SHIFT for x below 43690
	localparam int              DIV25_SHIFT = 20;
	localparam logic [15:0]     DIV25_MULT  = 16'd41944;
	localparam logic [4:0]      DIVISOR_25  = 5'd25;

	// weekday arithmetic
	localparam logic [3:0]       WEEK_LEN = 4'd7;
	localparam logic [DOW_W-1:0] DOW_SAT  = 3'd6;
	localparam logic [DOW_W-1:0] DOW_LAST = 3'd6;

	// month and year lengths
	localparam logic [MLEN_W-1:0] FEB_DAYS      = 5'd28;
	localparam logic [MLEN_W-1:0] FEB_DAYS_LEAP = 5'd29;
	localparam logic [DOY_W-1:0]  YEAR_DAYS      = 9'd365;
	localparam logic [DOY_W-1:0]  YEAR_DAYS_LEAP = 9'd366;

	// weekend mask after reset: friday and saturday
	localparam logic [MASK_W-1:0] WEEKEND_MASK_RESET = 7'd96;

	// days in each month, common year
	localparam logic [MLEN_W-1:0] MONTH_DAYS [NUM_MONTHS] = '{
		5'd31, 5'd28, 5'd31, 5'd30, 5'd31, 5'd30,
		5'd31, 5'd31, 5'd30, 5'd31, 5'd30, 5'd31
	};

	// days before the first of each month, common year
	localparam logic [DOY_W-1:0] DAYS_BEFORE [NUM_MONTHS] = '{
		9'd0,   9'd31,  9'd59,  9'd90,  9'd120, 9'd151,
		9'd181, 9'd212, 9'd243, 9'd273, 9'd304, 9'd334
	};

	// (31 * shifted month) / 12, shifted month is march = 1 .. february = 12
	localparam logic [4:0] SHIFT_TERM [NUM_MONTHS] = '{
		5'd28, 5'd31, 5'd2,  5'd5,  5'd7,  5'd10,
		5'd12, 5'd15, 5'd18, 5'd20, 5'd23, 5'd25
	};

	// calendar results handed from the calendar stages to the weekday stages
	typedef struct packed {
		logic              date_valid;
		logic              leap_year;
		logic [MLEN_W-1:0] month_length;
		logic [MLEN_W-1:0] days_to_month_end;
		logic [DOY_W-1:0]  days_to_year_end;
		logic [DAY_W-1:0]  day;
		logic [4:0]        shift_term;
		logic [YY_W-1:0]   yy;
	} cal_t;

endpackage

// ===== hdl/gdc_if.sv =====
// ----------------------------------------------------------------------------
// gdc_if
// valid/ready channels for the date request and the classification result
// ----------------------------------------------------------------------------

// date request channel
interface gdc_date_if;
	logic                         valid;
	logic                         ready;
	logic [gdc_pkg::DAY_W-1:0]    day;
	logic [gdc_pkg::MONTH_W-1:0]  month;
	logic [gdc_pkg::YEAR_W-1:0]   year;

	modport source (output valid, output day, output month, output year, input ready);
	modport sink (input valid, input day, input month, input year, output ready);
endinterface

// classification result channel
interface gdc_info_if;
	logic                        valid;
	logic                        ready;
	logic                        date_valid;
	logic [gdc_pkg::DOW_W-1:0]   day_of_week;
	logic                        leap_year;
	logic [gdc_pkg::MLEN_W-1:0]  month_length;
	logic                        end_of_week;
	logic                        weekend;
	logic                        business_day;
	logic [gdc_pkg::DOW_W-1:0]   days_to_week_end;
	logic [gdc_pkg::MLEN_W-1:0]  days_to_month_end;
	logic [gdc_pkg::DOY_W-1:0]   days_to_year_end;

	modport source (
		output valid, output date_valid, output day_of_week, output leap_year,
		output month_length, output end_of_week, output weekend, output business_day,
		output days_to_week_end, output days_to_month_end, output days_to_year_end,
		input ready
	);
	modport sink (
		input valid, input date_valid, input day_of_week, input leap_year,
		input month_length, input end_of_week, input weekend, input business_day,
		input days_to_week_end, input days_to_month_end, input days_to_year_end,
		output ready
	);
endinterface

// ===== hdl/gdc_calendar.sv =====
// ----------------------------------------------------------------------------
// gdc_calendar
// stages 1 and 2: month decode, leap year, date check and remaining days
// ----------------------------------------------------------------------------
module gdc_calendar (
	input  logic          clk,
	input  logic          arst_n,
	gdc_date_if.sink      date,
	output logic          cal_valid,
	input  logic          cal_ready,
	output gdc_pkg::cal_t cal
);

	// stage 1 combinational
	logic                           month_ok_c;
	logic [gdc_pkg::MONTH_W-1:0]    midx_c;
	logic                           jan_feb_c;
	logic [gdc_pkg::YY_W-1:0]       yy_c;
	logic [27:0]                    prod100_c;
	logic [25:0]                    prod400_c;

	// stage 1 registers
	logic                           v_s1;
	logic [gdc_pkg::DAY_W-1:0]      day_s1;
	logic [gdc_pkg::YEAR_W-1:0]     year_s1;
	logic                           month_ok_s1;
	logic                           is_feb_s1;
	logic                           after_feb_s1;
	logic [gdc_pkg::MLEN_W-1:0]     mlen_base_s1;
	logic [gdc_pkg::DOY_W-1:0]      doy_base_s1;
	logic [4:0]                     shift_s1;
	logic [gdc_pkg::YY_W-1:0]       yy_s1;
	logic [27:0]                    prod100_s1;
	logic [25:0]                    prod400_s1;

	// stage 2 combinational
	logic [7:0]                     q100_c;
	logic [5:0]                     q400_c;
	logic                           div4_c;
	logic                           div100_c;
	logic                           div400_c;
	logic                           leap_c;
	logic [gdc_pkg::MLEN_W-1:0]     mlen_c;
	logic                           day_ok_c;
	logic [gdc_pkg::DOY_W-1:0]      doy_c;
	logic [gdc_pkg::DOY_W-1:0]      ylen_c;
	gdc_pkg::cal_t                  cal_c;

	// stage 2 registers
	logic                           v_s2;
	gdc_pkg::cal_t                  cal_s2;

	// per-stage handshake
	logic ready_s1;
	logic ready_s2;

	assign ready_s2   = !v_s2 || cal_ready;
	assign ready_s1   = !v_s1 || ready_s2;
	assign date.ready = ready_s1;
	assign cal_valid  = v_s2;
	assign cal        = cal_s2;

	// month decode, shifted year and the year / 25 products
	always_comb begin
		month_ok_c = (date.month >= gdc_pkg::MONTH_JAN) && (date.month <= gdc_pkg::MONTH_DEC);
		midx_c     = month_ok_c ? (date.month - gdc_pkg::MONTH_JAN) : '0;
		jan_feb_c  = (date.month <= gdc_pkg::MONTH_FEB);
		yy_c       = gdc_pkg::YY_W'(date.year) + gdc_pkg::CYCLE_YEARS
		           - gdc_pkg::YY_W'(jan_feb_c);
		prod100_c  = 28'(date.year[13:2]) * 28'(gdc_pkg::DIV25_MULT);
		prod400_c  = 26'(date.year[13:4]) * 26'(gdc_pkg::DIV25_MULT);
	end

	// stage valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			if (ready_s1) begin
				v_s1 <= date.valid;
			end
			if (ready_s2) begin
				v_s2 <= v_s1;
			end
		end
	end

	// stage 1 payload
	always_ff @(posedge clk) begin
		if (ready_s1 && date.valid) begin
			day_s1       <= date.day;
			year_s1      <= date.year;
			month_ok_s1  <= month_ok_c;
			is_feb_s1    <= (date.month == gdc_pkg::MONTH_FEB);
			after_feb_s1 <= (date.month > gdc_pkg::MONTH_FEB);
			mlen_base_s1 <= gdc_pkg::MONTH_DAYS[midx_c];
			doy_base_s1  <= gdc_pkg::DAYS_BEFORE[midx_c];
			shift_s1     <= gdc_pkg::SHIFT_TERM[midx_c];
			yy_s1        <= yy_c;
			prod100_s1   <= prod100_c;
			prod400_s1   <= prod400_c;
		end
	end

	// leap year, month length, date check and days remaining
	always_comb begin
		q100_c   = prod100_s1[27:gdc_pkg::DIV25_SHIFT];
		q400_c   = prod400_s1[25:gdc_pkg::DIV25_SHIFT];
		div4_c   = (year_s1[1:0] == 2'd0);
		div100_c = div4_c && (year_s1[13:2] == 12'(12'(q100_c) * 12'(gdc_pkg::DIVISOR_25)));
		div400_c = (year_s1[3:0] == 4'd0)
		        && (year_s1[13:4] == 10'(10'(q400_c) * 10'(gdc_pkg::DIVISOR_25)));
		leap_c   = div400_c || (div4_c && !div100_c);
		if (is_feb_s1) begin
			mlen_c = leap_c ? gdc_pkg::FEB_DAYS_LEAP : gdc_pkg::FEB_DAYS;
		end else begin
			mlen_c = mlen_base_s1;
		end
		day_ok_c = month_ok_s1 && (day_s1 != '0) && (day_s1 <= mlen_c);
		doy_c    = doy_base_s1 + gdc_pkg::DOY_W'(day_s1)
		         + gdc_pkg::DOY_W'(leap_c && after_feb_s1);
		ylen_c   = leap_c ? gdc_pkg::YEAR_DAYS_LEAP : gdc_pkg::YEAR_DAYS;

		cal_c.date_valid        = day_ok_c;
		cal_c.leap_year         = leap_c;
		cal_c.month_length      = mlen_c;
		cal_c.days_to_month_end = mlen_c - day_s1 + gdc_pkg::MLEN_W'(1);
		cal_c.days_to_year_end  = ylen_c - doy_c + gdc_pkg::DOY_W'(1);
		cal_c.day               = day_s1;
		cal_c.shift_term        = shift_s1;
		cal_c.yy                = yy_s1;
	end

	// stage 2 payload
	always_ff @(posedge clk) begin
		if (ready_s2 && v_s1) begin
			cal_s2 <= cal_c;
		end
	end

endmodule

// ===== hdl/gdc_weekday.sv =====
// ----------------------------------------------------------------------------
// gdc_weekday
// stages 3 to 5: weekday sum, mod 7 reduction, flags and output register
// ----------------------------------------------------------------------------
module gdc_weekday (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic [gdc_pkg::MASK_W-1:0]  weekend_mask,
	input  logic                        cal_valid,
	output logic                        cal_ready,
	input  gdc_pkg::cal_t               cal,
	gdc_info_if.source                  info
);

	typedef struct packed {
		logic                       date_valid;
		logic [gdc_pkg::DOW_W-1:0]  day_of_week;
		logic                       leap_year;
		logic [gdc_pkg::MLEN_W-1:0] month_length;
		logic                       end_of_week;
		logic                       weekend;
		logic                       business_day;
		logic [gdc_pkg::DOW_W-1:0]  days_to_week_end;
		logic [gdc_pkg::MLEN_W-1:0] days_to_month_end;
		logic [gdc_pkg::DOY_W-1:0]  days_to_year_end;
	} res_t;

	// stage 3 combinational and registers
	logic [28:0]               prod100_c;
	logic [26:0]               prod400_c;
	logic                      v_s3;
	gdc_pkg::cal_t             cal_s3;
	logic [28:0]               prod100_s3;
	logic [26:0]               prod400_s3;

	// stage 4 combinational and registers
	logic [8:0]                q100_c;
	logic [6:0]                q400_c;
	logic [gdc_pkg::SUM_W-1:0] sum_c;
	logic                      v_s4;
	gdc_pkg::cal_t             cal_s4;
	logic [gdc_pkg::SUM_W-1:0] sum_s4;

	// stage 5 combinational and registers
	logic [5:0]                digits_c;
	logic [3:0]                fold_c;
	logic [gdc_pkg::DOW_W-1:0] dow_c;
	logic                      we_c;
	res_t                      res_c;
	logic                      v_s5;
	res_t                      res_s5;

	// per-stage handshake
	logic ready_s3;
	logic ready_s4;
	logic ready_s5;

	assign ready_s5  = !v_s5 || info.ready;
	assign ready_s4  = !v_s4 || ready_s5;
	assign ready_s3  = !v_s3 || ready_s4;
	assign cal_ready = ready_s3;

	// shifted year / 100 and / 400 as (year / 4) / 25 and (year / 16) / 25
	always_comb begin
		prod100_c = 29'(cal.yy[14:2]) * 29'(gdc_pkg::DIV25_MULT);
		prod400_c = 27'(cal.yy[14:4]) * 27'(gdc_pkg::DIV25_MULT);
	end

	// weekday sum before reduction
	always_comb begin
		q100_c = prod100_s3[28:gdc_pkg::DIV25_SHIFT];
		q400_c = prod400_s3[26:gdc_pkg::DIV25_SHIFT];
		sum_c  = gdc_pkg::SUM_W'(cal_s3.day) + cal_s3.yy
		       + gdc_pkg::SUM_W'(cal_s3.yy[14:2]) - gdc_pkg::SUM_W'(q100_c)
		       + gdc_pkg::SUM_W'(q400_c) + gdc_pkg::SUM_W'(cal_s3.shift_term);
	end

	// mod 7 by folding octal digits (8 is 1 mod 7), then the result fields
	always_comb begin
		digits_c = 6'(sum_s4[2:0]) + 6'(sum_s4[5:3]) + 6'(sum_s4[8:6])
		         + 6'(sum_s4[11:9]) + 6'(sum_s4[14:12]);
		fold_c   = 4'(digits_c[5:3]) + 4'(digits_c[2:0]);
		if (fold_c >= gdc_pkg::WEEK_LEN) begin
			dow_c = 3'(fold_c - gdc_pkg::WEEK_LEN);
		end else begin
			dow_c = fold_c[2:0];
		end
		we_c = weekend_mask[dow_c];

		res_c = '0;
		if (cal_s4.date_valid) begin
			res_c.date_valid        = 1'b1;
			res_c.day_of_week       = dow_c;
			res_c.leap_year         = cal_s4.leap_year;
			res_c.month_length      = cal_s4.month_length;
			res_c.end_of_week       = (dow_c == gdc_pkg::DOW_SAT);
			res_c.weekend           = we_c;
			res_c.business_day      = !we_c;
			res_c.days_to_week_end  = gdc_pkg::DOW_LAST - dow_c;
			res_c.days_to_month_end = cal_s4.days_to_month_end;
			res_c.days_to_year_end  = cal_s4.days_to_year_end;
		end
	end

	// stage valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else begin
			if (ready_s3) begin
				v_s3 <= cal_valid;
			end
			if (ready_s4) begin
				v_s4 <= v_s3;
			end
			if (ready_s5) begin
				v_s5 <= v_s4;
			end
		end
	end

	// stage payloads
	always_ff @(posedge clk) begin
		if (ready_s3 && cal_valid) begin
			cal_s3     <= cal;
			prod100_s3 <= prod100_c;
			prod400_s3 <= prod400_c;
		end
		if (ready_s4 && v_s3) begin
			cal_s4 <= cal_s3;
			sum_s4 <= sum_c;
		end
		if (ready_s5 && v_s4) begin
			res_s5 <= res_c;
		end
	end

	// output register drives the result channel
	assign info.valid             = v_s5;
	assign info.date_valid        = res_s5.date_valid;
	assign info.day_of_week       = res_s5.day_of_week;
	assign info.leap_year         = res_s5.leap_year;
	assign info.month_length      = res_s5.month_length;
	assign info.end_of_week       = res_s5.end_of_week;
	assign info.weekend           = res_s5.weekend;
	assign info.business_day      = res_s5.business_day;
	assign info.days_to_week_end  = res_s5.days_to_week_end;
	assign info.days_to_month_end = res_s5.days_to_month_end;
	assign info.days_to_year_end  = res_s5.days_to_year_end;

endmodule

// ===== hdl/gregorian_date_classifier.sv =====
// ----------------------------------------------------------------------------
// gregorian_date_classifier
// classifies one gregorian date per request: validity, leap year, weekday,
// weekend and business-day flags, and days left in week, month and year
// ----------------------------------------------------------------------------
// Five-stage pipeline: a date request goes in each clock while ready is high, and
// its result leaves stage 5 on the info channel, one result per request in
// request order. Every stage has its own valid bit and takes a new request
// whenever it is empty or its successor moves, so the date channel stays
// ready while any stage holds a bubble, even with a result waiting at the
// output; ready drops only when all five stages are full and info is stalled.
// Stages: 1 month decode and the year / 25 products, 2 leap year and
// remaining days, 3 shifted-year / 25 products, 4 weekday sum, 5 mod 7,
// flags and output register. The weekend mask is written through cfg_we /
// cfg_wdata and resets to friday and saturday; the user must write it only while
// no request is in flight; the block does not enforce it. A month outside 1..12
// or a day outside the month gives date_valid low and every other field zero.
module gregorian_date_classifier (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_we,
	input  logic [gdc_pkg::MASK_W-1:0]  cfg_wdata,
	gdc_date_if.sink                    date,
	gdc_info_if.source                  info
);

	logic [gdc_pkg::MASK_W-1:0] weekend_mask_q;
	logic                       cal_valid;
	logic                       cal_ready;
	gdc_pkg::cal_t              cal;

	// weekend mask register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			weekend_mask_q <= gdc_pkg::WEEKEND_MASK_RESET;
		end else if (cfg_we) begin
			weekend_mask_q <= cfg_wdata;
		end
	end

	// calendar stages
	gdc_calendar u_calendar (
		.clk       (clk),
		.arst_n    (arst_n),
		.date      (date),
		.cal_valid (cal_valid),
		.cal_ready (cal_ready),
		.cal       (cal)
	);

	// weekday stages and output register
	gdc_weekday u_weekday (
		.clk          (clk),
		.arst_n       (arst_n),
		.weekend_mask (weekend_mask_q),
		.cal_valid    (cal_valid),
		.cal_ready    (cal_ready),
		.cal          (cal),
		.info         (info)
	);

endmodule

// ===== hdl/gdc_checker.sv =====
// ----------------------------------------------------------------------------
// gdc_checker
// port-level checks on the classification results of the top level
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module gdc_checker (
	input logic                        clk,
	input logic                        arst_n,
	input logic                        info_valid,
	input logic                        info_ready,
	input logic                        date_valid,
	input logic [gdc_pkg::DOW_W-1:0]   day_of_week,
	input logic                        leap_year,
	input logic [gdc_pkg::MLEN_W-1:0]  month_length,
	input logic                        end_of_week,
	input logic                        weekend,
	input logic                        business_day,
	input logic [gdc_pkg::DOW_W-1:0]   days_to_week_end,
	input logic [gdc_pkg::MLEN_W-1:0]  days_to_month_end,
	input logic [gdc_pkg::DOY_W-1:0]   days_to_year_end
);

	// an invalid date carries nothing but the flag
	`GDC_ASSERT(a_invalid_zero, clk, arst_n, (info_valid && !date_valid) |-> (day_of_week == '0 && !leap_year && month_length == '0 && !end_of_week && !weekend && !business_day && days_to_week_end == '0 && days_to_month_end == '0 && days_to_year_end == '0))

	// weekday fields agree with each other
	`GDC_ASSERT(a_week_fields, clk, arst_n, (info_valid && date_valid) |-> ((4'(days_to_week_end) + 4'(day_of_week)) == 4'd6 && end_of_week == (day_of_week == 3'd6) && business_day != weekend))

	// month fields agree, and a 29-day month only in a leap year
	`GDC_ASSERT(a_month_fields, clk, arst_n, (info_valid && date_valid) |-> (days_to_month_end != '0 && days_to_month_end <= month_length && days_to_year_end != '0 && (month_length != 5'd29 || leap_year)))

	// a stalled result stays offered
	`GDC_ASSERT_STALL(a_info_hold, clk, arst_n, info_valid, info_ready)

endmodule

bind gregorian_date_classifier gdc_checker u_gdc_checker (
	.clk               (clk),
	.arst_n            (arst_n),
	.info_valid        (info.valid),
	.info_ready        (info.ready),
	.date_valid        (info.date_valid),
	.day_of_week       (info.day_of_week),
	.leap_year         (info.leap_year),
	.month_length      (info.month_length),
	.end_of_week       (info.end_of_week),
	.weekend           (info.weekend),
	.business_day      (info.business_day),
	.days_to_week_end  (info.days_to_week_end),
	.days_to_month_end (info.days_to_month_end),
	.days_to_year_end  (info.days_to_year_end)
);

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for the gregorian date classifier: directed calendar
// corner cases, then random dates under several weekend masks and stall mixes,
// each result compared field by field against a calendar predictor
// ----------------------------------------------------------------------------
module tb_top;

	// field types
	typedef logic [gdc_pkg::DAY_W-1:0]   day_t;
	typedef logic [gdc_pkg::MONTH_W-1:0] month_t;
	typedef logic [gdc_pkg::YEAR_W-1:0]  year_t;
	typedef logic [gdc_pkg::DOW_W-1:0]   dow_t;
	typedef logic [gdc_pkg::MLEN_W-1:0]  mlen_t;
	typedef logic [gdc_pkg::DOY_W-1:0]   doy_t;
	typedef logic [gdc_pkg::MASK_W-1:0]  mask_t;

	// thirty-day months
	localparam month_t MONTH_APR = 4'd4;
	localparam month_t MONTH_JUN = 4'd6;
	localparam month_t MONTH_SEP = 4'd9;
	localparam month_t MONTH_NOV = 4'd11;

	localparam int DRAIN_CYCLES   = 12;
	localparam int WATCHDOG_LIMIT = 4000;
	localparam int SEGMENT_ITEMS  = 250;

	typedef struct packed {
		day_t   day;
		month_t month;
		year_t  year;
	} date_req_t;

	typedef struct packed {
		logic  date_valid;
		dow_t  day_of_week;
		logic  leap_year;
		mlen_t month_length;
		logic  end_of_week;
		logic  weekend;
		logic  business_day;
		dow_t  days_to_week_end;
		mlen_t days_to_month_end;
		doy_t  days_to_year_end;
	} date_info_t;

	logic  clk;
	logic  arst_n;
	logic  cfg_we;
	mask_t cfg_wdata;

	gdc_date_if date_ch ();
	gdc_info_if info_ch ();

	gregorian_date_classifier u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.date      (date_ch),
		.info      (info_ch)
	);

	date_req_t  pending_dates [$];
	date_info_t expected_info [$];
	mask_t      weekend_mask_model;
	int         src_idle_pct;
	int         snk_idle_pct;
	int         fail_count = 0;
	int         stall_cycles;

	// gregorian leap rule, year zero included
	function automatic bit is_leap_year(int unsigned y);
		return (y % 400 == 0) || ((y % 4 == 0) && (y % 100 != 0));
	endfunction

	function automatic int unsigned days_in_month(month_t m, bit leap);
		if (m == gdc_pkg::MONTH_FEB)
			return leap ? 29 : 28;
		if (m == MONTH_APR || m == MONTH_JUN || m == MONTH_SEP || m == MONTH_NOV)
			return 30;
		return 31;
	endfunction

	// expected classification of one date under the given weekend mask
	function automatic date_info_t classify_date(date_req_t req, mask_t mask);
		date_info_t  res;
		int unsigned d, m, y, mlen, jan_feb, yy, sm, total, wd, doy;
		bit          leap;
		res = '0;
		d = 32'(req.day);
		m = 32'(req.month);
		y = 32'(req.year);
		if (req.month < gdc_pkg::MONTH_JAN || req.month > gdc_pkg::MONTH_DEC)
			return res;
		leap = is_leap_year(y);
		mlen = days_in_month(req.month, leap);
		if (d < 1 || d > mlen)
			return res;
		// january and february count as months 11 and 12 of the prior year;
		// one extra 400-year cycle keeps year zero from going negative
		jan_feb = (req.month <= gdc_pkg::MONTH_FEB) ? 1 : 0;
		yy = y + 400 - jan_feb;
		sm = m + 12 * jan_feb - 2;
		total = d + yy + yy / 4 - yy / 100 + yy / 400 + (31 * sm) / 12;
		wd = total % 7;
		doy = d;
		for (int unsigned k = 1; k < m; k++)
			doy += days_in_month(month_t'(k), leap);
		res.date_valid        = 1'b1;
		res.day_of_week       = dow_t'(wd);
		res.leap_year         = leap;
		res.month_length      = mlen_t'(mlen);
		res.end_of_week       = (dow_t'(wd) == gdc_pkg::DOW_SAT);
		res.weekend           = mask[wd[2:0]];
		res.business_day      = !mask[wd[2:0]];
		res.days_to_week_end  = gdc_pkg::DOW_LAST - dow_t'(wd);
		res.days_to_month_end = mlen_t'(mlen - d + 1);
		res.days_to_year_end  = doy_t'((leap ? 366 : 365) - doy + 1);
		return res;
	endfunction

	// mostly well-formed dates, with month ends, leap centuries and bad fields
	function automatic date_req_t random_date();
		date_req_t   req;
		int unsigned r, mlen;
		r = $urandom_range(99);
		if (r < 40)
			req.year = year_t'($urandom_range(16383));
		else if (r < 70)
			req.year = year_t'($urandom_range(9999, 1));
		else if (r < 85)
			req.year = year_t'(100 * $urandom_range(163));
		else
			req.year = year_t'(4 * $urandom_range(4095));
		if ($urandom_range(99) < 88)
			req.month = month_t'($urandom_range(12, 1));
		else
			req.month = month_t'($urandom_range(15));
		mlen = days_in_month(req.month, is_leap_year(32'(req.year)));
		r = $urandom_range(99);
		if (r < 65)
			req.day = day_t'($urandom_range(mlen, 1));
		else if (r < 77)
			req.day = day_t'(mlen);
		else if (r < 82)
			req.day = day_t'(1);
		else if (r < 88)
			req.day = day_t'((mlen == 31) ? 0 : mlen + 1);
		else
			req.day = day_t'($urandom_range(31));
		return req;
	endfunction

	task automatic check_field(string name, logic [15:0] exp_v, logic [15:0] act_v);
		if (exp_v !== act_v) begin
			$error("%s mismatch: expected %0d, actual %0d", name, exp_v, act_v);
			fail_count++;
		end
	endtask

	task automatic push_date(int unsigned d, int unsigned m, int unsigned y);
		date_req_t req;
		req.day = day_t'(d);
		req.month = month_t'(m);
		req.year = year_t'(y);
		pending_dates.push_back(req);
	endtask

	// wait until every request has come back, then let the pipeline settle
	task automatic wait_idle();
		while (pending_dates.size() != 0 || date_ch.valid || expected_info.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_weekend_mask(mask_t mask);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= mask;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic run_random(mask_t mask, int src_pct, int snk_pct);
		write_weekend_mask(mask);
		src_idle_pct = src_pct;
		snk_idle_pct = snk_pct;
		@(negedge clk);
		repeat (SEGMENT_ITEMS) pending_dates.push_back(random_date());
		wait_idle();
	endtask

	// clock
	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// request driver: holds a request until it is taken, may idle between
	always @(posedge clk or negedge arst_n) begin : drive_requests
		date_req_t req;
		if (!arst_n) begin
			date_ch.valid <= 1'b0;
			date_ch.day <= '0;
			date_ch.month <= '0;
			date_ch.year <= '0;
		end else begin
			if (date_ch.valid && date_ch.ready) begin
				req.day = date_ch.day;
				req.month = date_ch.month;
				req.year = date_ch.year;
				expected_info.push_back(classify_date(req, weekend_mask_model));
			end
			if (!date_ch.valid || date_ch.ready) begin
				if (pending_dates.size() != 0 && $urandom_range(99) >= src_idle_pct) begin
					req = pending_dates.pop_front();
					date_ch.valid <= 1'b1;
					date_ch.day <= req.day;
					date_ch.month <= req.month;
					date_ch.year <= req.year;
				end else begin
					date_ch.valid <= 1'b0;
				end
			end
		end
	end

	// result monitor, random back-pressure, mask shadow and watchdog
	always @(posedge clk or negedge arst_n) begin : check_results
		date_info_t exp;
		if (!arst_n) begin
			info_ch.ready <= 1'b0;
			weekend_mask_model <= gdc_pkg::WEEKEND_MASK_RESET;
			stall_cycles <= 0;
		end else begin
			info_ch.ready <= ($urandom_range(99) >= snk_idle_pct);
			if (cfg_we)
				weekend_mask_model <= cfg_wdata;
			if (info_ch.valid && info_ch.ready) begin
				if (expected_info.size() == 0) begin
					$error("result with no request outstanding");
					fail_count++;
				end else begin
					exp = expected_info.pop_front();
					check_field("date_valid", 16'(exp.date_valid),
						16'(info_ch.date_valid));
					check_field("day_of_week", 16'(exp.day_of_week),
						16'(info_ch.day_of_week));
					check_field("leap_year", 16'(exp.leap_year),
						16'(info_ch.leap_year));
					check_field("month_length", 16'(exp.month_length),
						16'(info_ch.month_length));
					check_field("end_of_week", 16'(exp.end_of_week),
						16'(info_ch.end_of_week));
					check_field("weekend", 16'(exp.weekend),
						16'(info_ch.weekend));
					check_field("business_day", 16'(exp.business_day),
						16'(info_ch.business_day));
					check_field("days_to_week_end", 16'(exp.days_to_week_end),
						16'(info_ch.days_to_week_end));
					check_field("days_to_month_end", 16'(exp.days_to_month_end),
						16'(info_ch.days_to_month_end));
					check_field("days_to_year_end", 16'(exp.days_to_year_end),
						16'(info_ch.days_to_year_end));
				end
			end
			// nothing moving on either channel for too long
			if ((date_ch.valid && date_ch.ready) || (info_ch.valid && info_ch.ready) || cfg_we)
				stall_cycles <= 0;
			else
				stall_cycles <= stall_cycles + 1;
			if (stall_cycles >= WATCHDOG_LIMIT) begin
				$error("watchdog: no request or result moved for %0d cycles", stall_cycles);
				$display("status: fail");
				$finish;
			end
		end
	end

	// stimulus sequence
	initial begin
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_wdata = '0;
		src_idle_pct = 10;
		snk_idle_pct = 56;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;

		// directed corners under the reset mask
		@(negedge clk);
		push_date(1, 1, 1);
		push_date(31, 12, 9999);
		push_date(1, 1, 0);
		push_date(31, 12, 16383);
		push_date(29, 2, 2000);
		push_date(29, 2, 1900);
		push_date(28, 2, 1900);
		push_date(29, 2, 2024);
		push_date(29, 2, 2023);
		push_date(1, 3, 2000);
		push_date(31, 12, 2000);
		push_date(0, 5, 2020);
		push_date(31, 4, 2021);
		push_date(30, 4, 2021);
		push_date(5, 0, 2021);
		push_date(1, 13, 2021);
		push_date(31, 15, 16383);
		// one full week, sunday through saturday
		for (int k = 1; k <= 7; k++)
			push_date(k, 10, 2023);
		wait_idle();

		// random dates under several masks and stall mixes
		run_random(7'h00, 10, 56);
		run_random(7'h7f, 10, 56);
		run_random(mask_t'($urandom_range(127)), 56, 10);
		run_random(7'h01, 56, 10);
		run_random(mask_t'($urandom_range(127)), 0, 0);
		run_random(gdc_pkg::WEEKEND_MASK_RESET, 0, 0);

		if (fail_count == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule
